[hdl/pced_pkg.sv]
// Shared types, constants and helpers for the Potts copy energy delta pipeline.
package pced_pkg;

	localparam int TAG_W       = 8;
	localparam int AREA_W      = 12;
	localparam int CONTACT_W   = 16;
	localparam int GAIN_W      = 32;
	localparam int RESULT_W    = 40;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 2;

	// areas above this are clamped before use
	localparam int MAX_CELL_AREA = 4095;

	localparam logic [CFG_INDEX_W-1:0] REG_CONTACT_CELL_MEDIUM = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CONTACT_CELL_CELL   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_AREA         = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_GAIN         = 2'd3;

	typedef struct packed {
		logic [TAG_W-1:0]  target_tag;
		logic [TAG_W-1:0]  source_tag;
		logic [TAG_W-1:0]  neighbor_tag_0;
		logic [TAG_W-1:0]  neighbor_tag_1;
		logic [TAG_W-1:0]  neighbor_tag_2;
		logic [TAG_W-1:0]  neighbor_tag_3;
		logic [TAG_W-1:0]  neighbor_tag_4;
		logic [TAG_W-1:0]  neighbor_tag_5;
		logic [TAG_W-1:0]  neighbor_tag_6;
		logic [TAG_W-1:0]  neighbor_tag_7;
		logic [AREA_W-1:0] target_area_now;
		logic [AREA_W-1:0] source_area_now;
	} copy_item_t;

	typedef struct packed {
		logic signed [RESULT_W-1:0] contact_delta;
		logic signed [RESULT_W-1:0] volume_delta;
		logic signed [RESULT_W-1:0] energy_delta;
	} delta_item_t;

	// saturate a 42-bit signed value to the 40-bit result range
	function automatic logic signed [RESULT_W-1:0] sat_result(input logic signed [41:0] v);
		logic signed [41:0] hi;
		logic signed [41:0] lo;
		hi = 42'sh0_7F_FFFF_FFFF;
		lo = -42'sh0_80_0000_0000;
		if (v > hi) begin
			return RESULT_W'(hi);
		end else if (v < lo) begin
			return RESULT_W'(lo);
		end
		return v[RESULT_W-1:0];
	endfunction

endpackage

[hdl/pced_if.sv]
// Valid/ready channel interfaces for copy attempts and energy results.
interface pced_in_if;
	import pced_pkg::*;
	logic       valid;
	logic       ready;
	copy_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface pced_out_if;
	import pced_pkg::*;
	logic        valid;
	logic        ready;
	delta_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

[hdl/potts_copy_energy_delta.sv]
// Energy change of one proposed 2D cellular Potts copy: contact, area and total terms.
// Three-stage pipeline, one copy attempt accepted per clock unless a stalled output has
// filled it. Stage 1 sums the eight neighbor adhesion differences and forms the integer
// area factor; stage 2 multiplies the factor by the 32-bit volume gain; stage 3 rounds the
// Q.24 product to 16 fraction bits, saturates, and adds the contact term. Each stage holds
// its own valid bit and only stalls when the stage after it is full and stalled, so gaps
// close up and a waiting result does not block new items. Configuration writes take effect
// at once and must only be issued while the pipeline is empty.
module potts_copy_energy_delta (
	input  logic                               clk,
	input  logic                               arst_n,
	pced_in_if.sink                            copy,
	pced_out_if.source                         delta,
	input  logic                               cfg_we,
	input  logic [pced_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [pced_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pced_pkg::*;

	localparam int CSUM_W   = 20;	// sum of eight 17-bit signed differences
	localparam int FACTOR_W = 17;
	localparam int PROD_W   = GAIN_W + 1 + FACTOR_W;

	logic [CONTACT_W-1:0] contact_cell_medium_q;
	logic [CONTACT_W-1:0] contact_cell_cell_q;
	logic [AREA_W-1:0]    target_area_q;
	logic [GAIN_W-1:0]    volume_gain_q;

	logic ready_s1, ready_s2, ready_s3;
	logic valid_s1, valid_s2, valid_s3;

	logic signed [CSUM_W-1:0]   contact_s1, contact_s2;
	logic signed [FACTOR_W-1:0] factor_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	delta_item_t                result_s3;

	logic signed [CSUM_W-1:0]   contact_sum;
	logic signed [CSUM_W-1:0]   nb_diff [8];
	logic signed [CSUM_W-1:0]   nb_pair [4];
	logic signed [CSUM_W-1:0]   nb_quad [2];
	logic signed [FACTOR_W-1:0] factor;
	logic [TAG_W-1:0]           nb [8];
	logic [AREA_W-1:0]          vt, vs;
	logic signed [FACTOR_W-1:0] t_term, s_term;
	logic signed [PROD_W-1:0]   prod_rnd;
	logic signed [41:0]         vol_wide;
	logic signed [RESULT_W-1:0] vol_sat, contact_ext;
	logic signed [41:0]         total_wide;

	function automatic logic [CONTACT_W-1:0] adhesion(input logic [TAG_W-1:0] a,
			input logic [TAG_W-1:0] b, input logic [CONTACT_W-1:0] j_medium,
			input logic [CONTACT_W-1:0] j_cell);
		if (a == b) begin
			return '0;
		end else if (a == '0 || b == '0) begin
			return j_medium;
		end
		return j_cell;
	endfunction

	function automatic logic [AREA_W-1:0] clamp_area(input logic [AREA_W-1:0] a);
		if (int'(a) > MAX_CELL_AREA) begin
			return AREA_W'(MAX_CELL_AREA);
		end
		return a;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contact_cell_medium_q <= '0;
			contact_cell_cell_q   <= '0;
			target_area_q         <= AREA_W'(1);
			volume_gain_q         <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONTACT_CELL_MEDIUM: contact_cell_medium_q <= cfg_data[CONTACT_W-1:0];
				REG_CONTACT_CELL_CELL:   contact_cell_cell_q   <= cfg_data[CONTACT_W-1:0];
				REG_TARGET_AREA:         target_area_q         <= cfg_data[AREA_W-1:0];
				REG_VOLUME_GAIN:         volume_gain_q         <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// per-stage flow control
	assign ready_s3   = !valid_s3 || delta.ready;
	assign ready_s2   = !valid_s2 || ready_s3;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign copy.ready = ready_s1;

	// stage 1: contact difference and area factor
	always_comb begin
		nb[0] = copy.payload.neighbor_tag_0;
		nb[1] = copy.payload.neighbor_tag_1;
		nb[2] = copy.payload.neighbor_tag_2;
		nb[3] = copy.payload.neighbor_tag_3;
		nb[4] = copy.payload.neighbor_tag_4;
		nb[5] = copy.payload.neighbor_tag_5;
		nb[6] = copy.payload.neighbor_tag_6;
		nb[7] = copy.payload.neighbor_tag_7;
		for (int n = 0; n < 8; n++) begin
			nb_diff[n] = $signed(CSUM_W'(adhesion(copy.payload.source_tag, nb[n],
					contact_cell_medium_q, contact_cell_cell_q)))
				- $signed(CSUM_W'(adhesion(copy.payload.target_tag, nb[n],
					contact_cell_medium_q, contact_cell_cell_q)));
		end
		// balanced adder tree over the eight neighbors
		for (int k = 0; k < 4; k++) begin
			nb_pair[k] = nb_diff[2 * k] + nb_diff[2 * k + 1];
		end
		for (int k = 0; k < 2; k++) begin
			nb_quad[k] = nb_pair[2 * k] + nb_pair[2 * k + 1];
		end
		contact_sum = nb_quad[0] + nb_quad[1];

		vt = clamp_area(copy.payload.target_area_now);
		vs = clamp_area(copy.payload.source_area_now);
		// retracting target: 1 - 2(Vt - V0); expanding source: 1 + 2(Vs - V0)
		t_term = '0;
		s_term = '0;
		if (copy.payload.target_tag != '0) begin
			t_term = FACTOR_W'(1) + $signed({4'b0, target_area_q, 1'b0})
				- $signed({4'b0, vt, 1'b0});
		end
		if (copy.payload.source_tag != '0) begin
			s_term = FACTOR_W'(1) + $signed({4'b0, vs, 1'b0})
				- $signed({4'b0, target_area_q, 1'b0});
		end
		factor = t_term + s_term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= copy.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && copy.valid) begin
			contact_s1 <= contact_sum;
			factor_s1  <= factor;
		end
	end

	// stage 2: gain multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			prod_s2    <= $signed({1'b0, volume_gain_q}) * factor_s1;
			contact_s2 <= contact_s1;
		end
	end

	// stage 3: round half up to Q.16, saturate, total
	always_comb begin
		prod_rnd    = (prod_s2 + $signed(PROD_W'(128))) >>> 8;
		vol_wide    = 42'(prod_rnd);
		vol_sat     = sat_result(vol_wide);
		contact_ext = {{(RESULT_W - CSUM_W - 8){contact_s2[CSUM_W-1]}}, contact_s2, 8'b0};
		total_wide  = 42'(contact_ext) + 42'(vol_sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			result_s3.contact_delta <= contact_ext;
			result_s3.volume_delta  <= vol_sat;
			result_s3.energy_delta  <= sat_result(total_wide);
		end
	end

	assign delta.valid   = valid_s3;
	assign delta.payload = result_s3;

endmodule
